// ===== src/scfe_pkg.sv =====
// Shared types, constants and helpers of the stepper command frame encoder.
package scfe_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int NUM_REGS    = 7;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int SPEED_W     = 12;
    localparam int BYTE_IDX_W  = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MOTOR_ID     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_SPD  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SWEEP_PULSES = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PULSES_PX    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_MAX   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT_DIR   = 3'd6;

    // command codes
    localparam logic [2:0] CMD_ENABLE = 3'd0;
    localparam logic [2:0] CMD_RUN    = 3'd1;
    localparam logic [2:0] CMD_STOP   = 3'd2;
    localparam logic [2:0] CMD_MOVE   = 3'd3;
    localparam logic [2:0] CMD_CENTER = 3'd4;
    localparam logic [2:0] CMD_SWEEP  = 3'd5;

    // frame bytes
    localparam logic [7:0] OP_ENABLE  = 8'hF3;
    localparam logic [7:0] ENABLE_ARG = 8'hAB;
    localparam logic [7:0] OP_SPEED   = 8'hF6;
    localparam logic [7:0] OP_MOVE    = 8'hFD;
    localparam logic [7:0] TAIL_BYTE  = 8'h6B;
    localparam logic [7:0] CODE_POS   = 8'h01;
    localparam logic [7:0] CODE_NEG   = 8'h00;
    localparam logic [7:0] PAD_BYTE   = 8'h00;

    localparam logic [15:0] SPEED_LIMIT = 16'd3000;

    // last byte index of each frame kind
    localparam logic [BYTE_IDX_W-1:0] LAST_ENABLE = 4'd3;
    localparam logic [BYTE_IDX_W-1:0] LAST_SPEED  = 4'd7;
    localparam logic [BYTE_IDX_W-1:0] LAST_MOVE   = 4'd12;

    typedef enum logic [1:0] {
        FRAME_ENABLE,
        FRAME_SPEED,
        FRAME_MOVE
    } frame_kind_t;

    typedef struct packed {
        logic [2:0]         cmd;
        logic               dir_positive;
        logic [15:0]        speed;
        logic [31:0]        pulse_count;
        logic signed [15:0] pixel_error;
    } command_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } result_t;

    typedef struct packed {
        logic [7:0]  motor_id;
        logic [15:0] default_speed;
        logic [31:0] sweep_pulses;
        logic [7:0]  pulses_per_pixel;
        logic [14:0] deadband_px;
        logic [31:0] center_max_pulses;
        logic        invert_direction;
    } cfg_t;

    // one classified frame, waiting for the back end
    typedef struct packed {
        frame_kind_t        kind;
        logic               positive;
        logic [SPEED_W-1:0] speed;
        logic [31:0]        pulses;
    } frame_desc_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              empty;
        logic              full;
    } q_status_t;

    function automatic logic [SPEED_W-1:0] clamp_speed(input logic [15:0] s);
        logic [15:0] c;
        c = (s > SPEED_LIMIT) ? SPEED_LIMIT : s;
        return c[SPEED_W-1:0];
    endfunction

endpackage

// ===== src/stepper_command_frame_encoder_top.sv =====
// Top level of the stepper command frame encoder: config registers, front, queue, back.
//
// Use:
//   - Command channel: drive command and raise start; the item is taken at a
//     rising edge where start is high and busy is low.
//   - Result channel: each frame byte shows on result for one cycle with
//     result_valid high; result.last_byte marks the end of the frame. The
//     receiver cannot stall; bytes leave back to back.
//   - Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data;
//     cfg_ready is always high, indexes past the register list are dropped.
//     Write only while the block is idle.
// Path: the first byte passes the front stage register, the queue, the
// back end's descriptor register and the output register on its way out.
// Throughput: the back end sends one byte a cycle; frames are 4, 8 or 13
// bytes long (enable, speed/stop, move). The two-entry queue lets
// the front take commands while a frame is going out; busy rises when the
// queue plus the front stage hold two items. Unused command codes pass the
// front stage and give no bytes.
// Reset: config registers go to their defaults, queue and back end empty.
module stepper_command_frame_encoder_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  scfe_pkg::command_t                  command,
    output logic                                result_valid,
    output scfe_pkg::result_t                   result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [scfe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [scfe_pkg::CFG_DATA_W-1:0]     cfg_data
);

    scfe_pkg::cfg_t         cfg_reg;
    scfe_pkg::q_status_t    q_status;
    scfe_pkg::frame_desc_t  push_desc;
    scfe_pkg::frame_desc_t  pop_desc;
    logic                   q_push;
    logic                   q_pop;
    logic                   cfg_we;

    // config port never stalls
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.motor_id          <= 8'd1;
            cfg_reg.default_speed     <= 16'd180;
            cfg_reg.sweep_pulses      <= 32'd700;
            cfg_reg.pulses_per_pixel  <= 8'd6;
            cfg_reg.deadband_px       <= 15'd18;
            cfg_reg.center_max_pulses <= 32'd1200;
            cfg_reg.invert_direction  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                scfe_pkg::REG_MOTOR_ID:     cfg_reg.motor_id          <= cfg_data[7:0];
                scfe_pkg::REG_DEFAULT_SPD:  cfg_reg.default_speed     <= cfg_data[15:0];
                scfe_pkg::REG_SWEEP_PULSES: cfg_reg.sweep_pulses      <= cfg_data;
                scfe_pkg::REG_PULSES_PX:    cfg_reg.pulses_per_pixel  <= cfg_data[7:0];
                scfe_pkg::REG_DEADBAND:     cfg_reg.deadband_px       <= cfg_data[14:0];
                scfe_pkg::REG_CENTER_MAX:   cfg_reg.center_max_pulses <= cfg_data;
                scfe_pkg::REG_INVERT_DIR:   cfg_reg.invert_direction  <= cfg_data[0];
                default:
                begin
                    // index beyond the register list: dropped
                end
            endcase
        end
    end

    // front: accept, scale, classify
    scfe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .command   (command),
        .cfg       (cfg_reg),
        .q_status  (q_status),
        .push      (q_push),
        .push_desc (push_desc)
    );

    scfe_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_desc (push_desc),
        .pop       (q_pop),
        .pop_desc  (pop_desc),
        .status    (q_status)
    );

    // back: byte sequencer and output register
    scfe_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_status     (q_status),
        .pop_desc     (pop_desc),
        .pop          (q_pop),
        .result_valid (result_valid),
        .result       (result)
    );

    // busy must keep the queue from overflowing
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (!q_status.full || q_pop))
        else $error("descriptor pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_status.empty)
        else $error("descriptor popped from an empty queue");

    // bytes of one frame leave without gaps
    a_frame_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last_byte) |=> result_valid)
        else $error("gap inside a frame");

endmodule

// ===== src/scfe_front.sv =====
// Front end: takes commands, scales the centering error, classifies into frame descriptors.
module scfe_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  scfe_pkg::command_t     command,
    input  scfe_pkg::cfg_t         cfg,
    input  scfe_pkg::q_status_t    q_status,
    output logic                   push,
    output scfe_pkg::frame_desc_t  push_desc
);

    logic                           stg_valid_reg, stg_valid_next;
    logic [2:0]                     stg_cmd_reg;
    logic                           stg_pos_reg;
    logic [scfe_pkg::SPEED_W-1:0]   stg_speed_reg;
    logic [31:0]                    stg_pulses_reg;
    logic                           stg_neg_reg;
    logic                           stg_nonzero_reg;
    logic                           stg_dead_reg;
    logic [24:0]                    stg_prod_reg;

    logic        accept;
    logic [16:0] mag;
    logic [scfe_pkg::QCNT_W:0] pending;

    assign pending = {1'b0, q_status.count} + {{scfe_pkg::QCNT_W{1'b0}}, stg_valid_reg};
    assign busy    = (pending >= (scfe_pkg::QCNT_W + 1)'(scfe_pkg::QUEUE_DEPTH));
    assign accept  = start && !busy;

    assign mag = command.pixel_error[15] ? (17'h10000 - {1'b0, command.pixel_error})
                                         : {1'b0, command.pixel_error};

    assign stg_valid_next = accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else
        begin
            stg_valid_reg <= stg_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stg_cmd_reg     <= command.cmd;
            stg_pos_reg     <= command.dir_positive;
            stg_speed_reg   <= scfe_pkg::clamp_speed(command.speed);
            stg_pulses_reg  <= command.pulse_count;
            stg_neg_reg     <= command.pixel_error[15];
            stg_nonzero_reg <= (command.pixel_error != 16'sd0);
            stg_dead_reg    <= (mag <= {2'b00, cfg.deadband_px});
            stg_prod_reg    <= {8'd0, mag} * {17'd0, cfg.pulses_per_pixel};
        end
    end

    // classification, after the registered product
    logic [31:0] center_p;
    scfe_pkg::frame_desc_t stop_desc;

    assign center_p = ({7'd0, stg_prod_reg} > cfg.center_max_pulses)
                      ? cfg.center_max_pulses : {7'd0, stg_prod_reg};

    always_comb
    begin
        stop_desc.kind     = scfe_pkg::FRAME_SPEED;
        stop_desc.positive = 1'b1;
        stop_desc.speed    = '0;
        stop_desc.pulses   = '0;

        push      = stg_valid_reg;
        push_desc = stop_desc;
        unique case (stg_cmd_reg)
            scfe_pkg::CMD_ENABLE:
            begin
                push_desc.kind = scfe_pkg::FRAME_ENABLE;
            end
            scfe_pkg::CMD_RUN:
            begin
                push_desc.positive = stg_pos_reg;
                push_desc.speed    = stg_speed_reg;
            end
            scfe_pkg::CMD_STOP:
            begin
                push_desc = stop_desc;
            end
            scfe_pkg::CMD_MOVE:
            begin
                if (stg_pulses_reg != 32'd0)
                begin
                    push_desc.kind     = scfe_pkg::FRAME_MOVE;
                    push_desc.positive = stg_pos_reg;
                    push_desc.speed    = stg_speed_reg;
                    push_desc.pulses   = stg_pulses_reg;
                end
            end
            scfe_pkg::CMD_CENTER:
            begin
                if (!stg_dead_reg && center_p != 32'd0)
                begin
                    push_desc.kind     = scfe_pkg::FRAME_MOVE;
                    push_desc.positive = !stg_neg_reg && stg_nonzero_reg;
                    push_desc.speed    = scfe_pkg::clamp_speed(cfg.default_speed);
                    push_desc.pulses   = center_p;
                end
            end
            scfe_pkg::CMD_SWEEP:
            begin
                if (cfg.sweep_pulses != 32'd0)
                begin
                    push_desc.kind     = scfe_pkg::FRAME_MOVE;
                    push_desc.positive = stg_pos_reg;
                    push_desc.speed    = scfe_pkg::clamp_speed(cfg.default_speed);
                    push_desc.pulses   = cfg.sweep_pulses;
                end
            end
            default:
            begin
                // unused codes give no frame
                push = 1'b0;
            end
        endcase
    end

endmodule

// ===== src/scfe_queue.sv =====
// Short descriptor queue between front and back ends.
module scfe_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  scfe_pkg::frame_desc_t  push_desc,
    input  logic                   pop,
    output scfe_pkg::frame_desc_t  pop_desc,
    output scfe_pkg::q_status_t    status
);

    scfe_pkg::frame_desc_t             entry_reg [scfe_pkg::QUEUE_DEPTH];
    logic [scfe_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [scfe_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [scfe_pkg::QCNT_W-1:0]       count_reg, count_next;

    localparam logic [scfe_pkg::QPTR_W-1:0] PTR_LAST =
        scfe_pkg::QPTR_W'(scfe_pkg::QUEUE_DEPTH - 1);

    assign status.count = count_reg;
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == scfe_pkg::QCNT_W'(scfe_pkg::QUEUE_DEPTH));
    assign pop_desc     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

// ===== src/scfe_back.sv =====
// Back end: walks a frame descriptor out one byte per cycle.
module scfe_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  scfe_pkg::cfg_t         cfg,
    input  scfe_pkg::q_status_t    q_status,
    input  scfe_pkg::frame_desc_t  pop_desc,
    output logic                   pop,
    output logic                   result_valid,
    output scfe_pkg::result_t      result
);

    scfe_pkg::frame_desc_t            cur_reg;
    logic                             active_reg, active_next;
    logic [scfe_pkg::BYTE_IDX_W-1:0]  idx_reg, idx_next;
    logic                             out_valid_reg;
    scfe_pkg::result_t                out_reg;

    logic [scfe_pkg::BYTE_IDX_W-1:0]  last_idx;
    logic                             at_last;
    logic [7:0]                       cur_byte;
    logic [7:0]                       dir_byte;
    logic [15:0]                      spd16;

    assign dir_byte = (cur_reg.positive ^ cfg.invert_direction)
                      ? scfe_pkg::CODE_POS : scfe_pkg::CODE_NEG;
    assign spd16    = {{(16 - scfe_pkg::SPEED_W){1'b0}}, cur_reg.speed};

    always_comb
    begin
        unique case (cur_reg.kind)
            scfe_pkg::FRAME_ENABLE: last_idx = scfe_pkg::LAST_ENABLE;
            scfe_pkg::FRAME_SPEED:  last_idx = scfe_pkg::LAST_SPEED;
            scfe_pkg::FRAME_MOVE:   last_idx = scfe_pkg::LAST_MOVE;
            default:                last_idx = scfe_pkg::LAST_MOVE;
        endcase
    end

    assign at_last = (idx_reg == last_idx);

    always_comb
    begin
        cur_byte = scfe_pkg::PAD_BYTE;
        unique case (cur_reg.kind)
            scfe_pkg::FRAME_ENABLE:
            begin
                case (idx_reg)
                    4'd0:    cur_byte = cfg.motor_id;
                    4'd1:    cur_byte = scfe_pkg::OP_ENABLE;
                    4'd2:    cur_byte = scfe_pkg::ENABLE_ARG;
                    default: cur_byte = cfg.motor_id + scfe_pkg::OP_ENABLE
                                        + scfe_pkg::ENABLE_ARG;
                endcase
            end
            scfe_pkg::FRAME_SPEED:
            begin
                case (idx_reg)
                    4'd0:    cur_byte = cfg.motor_id;
                    4'd1:    cur_byte = scfe_pkg::OP_SPEED;
                    4'd2:    cur_byte = dir_byte;
                    4'd3:    cur_byte = spd16[15:8];
                    4'd4:    cur_byte = spd16[7:0];
                    4'd7:    cur_byte = scfe_pkg::TAIL_BYTE;
                    default: cur_byte = scfe_pkg::PAD_BYTE;
                endcase
            end
            default:
            begin
                case (idx_reg)
                    4'd0:    cur_byte = cfg.motor_id;
                    4'd1:    cur_byte = scfe_pkg::OP_MOVE;
                    4'd2:    cur_byte = dir_byte;
                    4'd3:    cur_byte = spd16[15:8];
                    4'd4:    cur_byte = spd16[7:0];
                    4'd6:    cur_byte = cur_reg.pulses[31:24];
                    4'd7:    cur_byte = cur_reg.pulses[23:16];
                    4'd8:    cur_byte = cur_reg.pulses[15:8];
                    4'd9:    cur_byte = cur_reg.pulses[7:0];
                    4'd12:   cur_byte = scfe_pkg::TAIL_BYTE;
                    default: cur_byte = scfe_pkg::PAD_BYTE;
                endcase
            end
        endcase
    end

    // take the next frame when idle or on the last byte of the current one
    assign pop = (!active_reg || at_last) && !q_status.empty;

    always_comb
    begin
        active_next = active_reg;
        idx_next    = idx_reg;
        if (pop)
        begin
            active_next = 1'b1;
            idx_next    = '0;
        end
        else if (active_reg && at_last)
        begin
            active_next = 1'b0;
        end
        else if (active_reg)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            idx_reg       <= idx_next;
            out_valid_reg <= active_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= pop_desc;
        end
        out_reg.frame_byte <= cur_byte;
        out_reg.last_byte  <= at_last;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ===== sim/stepper_command_frame_encoder_top_test.sv =====
// Self-checking testbench for the stepper command frame encoder top level.
`timescale 1ns / 1ps

module stepper_command_frame_encoder_top_test;
    import scfe_pkg::*;

    localparam int LIMIT_CYCLES  = 250000;
    localparam int DRAIN_CYCLES  = 12;    // byte path: front stage, queue, descriptor and output registers
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 70;
    localparam int MAX_GAP       = 20;

    // codes the block must swallow without a frame
    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;
    // index past the register list, written to check it is dropped
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

    // ------------------------------------------------------------------
    // Frame predictor and byte checker. Holds its own register copy and
    // a queue of the bytes still owed by the block, oldest first.
    // ------------------------------------------------------------------
    class frame_byte_tracker;
        cfg_t    regs;
        result_t owed_bytes[$];
        int      errors;

        function new();
            regs.motor_id          = 8'd1;
            regs.default_speed     = 16'd180;
            regs.sweep_pulses      = 32'd700;
            regs.pulses_per_pixel  = 8'd6;
            regs.deadband_px       = 15'd18;
            regs.center_max_pulses = 32'd1200;
            regs.invert_direction  = 1'b0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_MOTOR_ID:     regs.motor_id          = data[7:0];
                REG_DEFAULT_SPD:  regs.default_speed     = data[15:0];
                REG_SWEEP_PULSES: regs.sweep_pulses      = data;
                REG_PULSES_PX:    regs.pulses_per_pixel  = data[7:0];
                REG_DEADBAND:     regs.deadband_px       = data[14:0];
                REG_CENTER_MAX:   regs.center_max_pulses = data;
                REG_INVERT_DIR:   regs.invert_direction  = data[0];
                default: ;
            endcase
        endfunction

        function void owe(logic [7:0] b, logic last);
            result_t r;
            r.frame_byte = b;
            r.last_byte  = last;
            owed_bytes.push_back(r);
        endfunction

        function logic [7:0] dir_byte(logic positive);
            return (positive ^ regs.invert_direction) ? CODE_POS : CODE_NEG;
        endfunction

        function logic [15:0] limit_speed(logic [15:0] s);
            return (s > 16'd3000) ? 16'd3000 : s;
        endfunction

        function void owe_speed_frame(logic positive, logic [15:0] s);
            logic [15:0] c;
            c = limit_speed(s);
            owe(regs.motor_id, 1'b0);
            owe(OP_SPEED, 1'b0);
            owe(dir_byte(positive), 1'b0);
            owe(c[15:8], 1'b0);
            owe(c[7:0], 1'b0);
            owe(PAD_BYTE, 1'b0);
            owe(PAD_BYTE, 1'b0);
            owe(TAIL_BYTE, 1'b1);
        endfunction

        // a move of zero pulses goes out as the stop frame
        function void owe_move_frame(logic positive, logic [15:0] s, logic [31:0] pulses);
            logic [15:0] c;
            c = limit_speed(s);
            if (pulses == 32'd0)
            begin
                owe_speed_frame(1'b1, 16'd0);
                return;
            end
            owe(regs.motor_id, 1'b0);
            owe(OP_MOVE, 1'b0);
            owe(dir_byte(positive), 1'b0);
            owe(c[15:8], 1'b0);
            owe(c[7:0], 1'b0);
            owe(PAD_BYTE, 1'b0);
            owe(pulses[31:24], 1'b0);
            owe(pulses[23:16], 1'b0);
            owe(pulses[15:8], 1'b0);
            owe(pulses[7:0], 1'b0);
            owe(PAD_BYTE, 1'b0);
            owe(PAD_BYTE, 1'b0);
            owe(TAIL_BYTE, 1'b1);
        endfunction

        function void note_command(command_t c);
            logic        neg;
            logic [16:0] mag;
            logic [31:0] p;
            case (c.cmd)
                CMD_ENABLE:
                begin
                    owe(regs.motor_id, 1'b0);
                    owe(OP_ENABLE, 1'b0);
                    owe(ENABLE_ARG, 1'b0);
                    owe(regs.motor_id + OP_ENABLE + ENABLE_ARG, 1'b1);
                end
                CMD_RUN:  owe_speed_frame(c.dir_positive, c.speed);
                CMD_STOP: owe_speed_frame(1'b1, 16'd0);
                CMD_MOVE: owe_move_frame(c.dir_positive, c.speed, c.pulse_count);
                CMD_CENTER:
                begin
                    neg = c.pixel_error[15];
                    mag = neg ? (17'h10000 - {1'b0, c.pixel_error}) : {1'b0, c.pixel_error};
                    if (mag <= {2'b00, regs.deadband_px})
                    begin
                        owe_speed_frame(1'b1, 16'd0);
                    end
                    else
                    begin
                        p = 32'(mag) * 32'(regs.pulses_per_pixel);
                        if (p > regs.center_max_pulses)
                            p = regs.center_max_pulses;
                        owe_move_frame(!neg, regs.default_speed, p);
                    end
                end
                CMD_SWEEP: owe_move_frame(c.dir_positive, regs.default_speed, regs.sweep_pulses);
                default: ;
            endcase
        endfunction

        function void check_byte(result_t got);
            result_t want;
            if (owed_bytes.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("[%0t] unexpected byte %02h last=%0b", $realtime,
                             got.frame_byte, got.last_byte);
                return;
            end
            want = owed_bytes.pop_front();
            if (got.frame_byte !== want.frame_byte || got.last_byte !== want.last_byte)
            begin
                errors++;
                if (errors <= 10)
                    $display("[%0t] byte mismatch: expected %02h last=%0b, got %02h last=%0b",
                             $realtime, want.frame_byte, want.last_byte,
                             got.frame_byte, got.last_byte);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, DUT and signals
    // ------------------------------------------------------------------
    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    command_t              command;
    logic                  result_valid;
    result_t               result;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    frame_byte_tracker tracker = new();
    int idle_pct;
    int cycle_count;

    always #2 clk = ~clk;

    stepper_command_frame_encoder_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Every strobed byte is taken at the edge that ends its cycle.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            tracker.check_byte(result);
    end

    // Watchdog: a hung handshake or a lost byte ends up here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    function automatic command_t mk_cmd(logic [2:0] op, logic dir, logic [15:0] spd,
                                        logic [31:0] pls, logic [15:0] err);
        command_t c;
        c.cmd          = op;
        c.dir_positive = dir;
        c.speed        = spd;
        c.pulse_count  = pls;
        c.pixel_error  = err;
        return c;
    endfunction

    // Present one item, hold it until taken, then maybe idle a while.
    // With no gap start stays high and the next item follows straight on.
    task automatic send_command(command_t c);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct)
            gap++;
        @(negedge clk);
        start   <= 1'b1;
        command <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        tracker.note_command(c);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Stop sending and let the block empty; spare codes owe nothing, so
    // also sit out the pipeline depth after the last owed byte.
    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (tracker.owed_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tracker.write_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_config(logic [31:0] motor, logic [31:0] dspd, logic [31:0] sweep,
                               logic [31:0] ppp, logic [31:0] db, logic [31:0] cmax,
                               logic [31:0] inv);
        write_reg(REG_MOTOR_ID, motor);
        write_reg(REG_DEFAULT_SPD, dspd);
        write_reg(REG_SWEEP_PULSES, sweep);
        write_reg(REG_PULSES_PX, ppp);
        write_reg(REG_DEADBAND, db);
        write_reg(REG_CENTER_MAX, cmax);
        write_reg(REG_INVERT_DIR, inv);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        command_t c;
        int       r;

        clk         = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        command     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        cycle_count = 0;
        idle_pct    = 36;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed, reset register values: every command and the speed,
        // pulse and deadband edges.
        send_command(mk_cmd(CMD_ENABLE, 1'b0, 16'd0, 32'd0, 16'd0));
        send_command(mk_cmd(CMD_RUN, 1'b1, 16'd0, 32'd0, 16'd0));
        send_command(mk_cmd(CMD_RUN, 1'b0, 16'd3000, 32'd0, 16'd0));
        send_command(mk_cmd(CMD_RUN, 1'b1, 16'd3001, 32'd0, 16'd0));
        send_command(mk_cmd(CMD_RUN, 1'b0, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF));
        send_command(mk_cmd(CMD_STOP, 1'b0, 16'hFFFF, 32'd5, 16'd0));
        send_command(mk_cmd(CMD_MOVE, 1'b1, 16'd500, 32'd0, 16'd0));
        send_command(mk_cmd(CMD_MOVE, 1'b0, 16'hFFFF, 32'hFFFF_FFFF, 16'd0));
        send_command(mk_cmd(CMD_CENTER, 1'b1, 16'd0, 32'd0, 16'd18));
        send_command(mk_cmd(CMD_CENTER, 1'b0, 16'd0, 32'd0, -16'sd19));
        send_command(mk_cmd(CMD_CENTER, 1'b0, 16'd0, 32'd0, 16'd19));
        send_command(mk_cmd(CMD_CENTER, 1'b1, 16'd0, 32'd0, 16'h7FFF));
        send_command(mk_cmd(CMD_CENTER, 1'b1, 16'd0, 32'd0, 16'h8000));
        send_command(mk_cmd(CMD_SWEEP, 1'b0, 16'd0, 32'd0, 16'd0));
        send_command(mk_cmd(CMD_SPARE_LO, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF));
        send_command(mk_cmd(CMD_SPARE_HI, 1'b0, 16'd0, 32'd0, 16'd0));
        wait_drained();

        // Inverted direction, zero scale and zero sweep: centering and sweep
        // both collapse to stop; enable checksum wraps.
        load_config(32'hFF, 32'hFFFF, 32'd0, 32'd0, 32'h7FFF, 32'd0, 32'd1);
        write_reg(REG_NONE, 32'hFFFF_FFFF);
        send_command(mk_cmd(CMD_ENABLE, 1'b1, 16'd0, 32'd0, 16'd0));
        send_command(mk_cmd(CMD_STOP, 1'b1, 16'd0, 32'd0, 16'd0));
        send_command(mk_cmd(CMD_MOVE, 1'b1, 16'd100, 32'd1, 16'd0));
        send_command(mk_cmd(CMD_CENTER, 1'b1, 16'd0, 32'd0, 16'h8000));
        send_command(mk_cmd(CMD_SWEEP, 1'b1, 16'd0, 32'd0, 16'd0));
        wait_drained();

        // Zero deadband, widest scale and limit: single pixel errors move.
        load_config(32'd0, 32'd0, 32'hFFFF_FFFF, 32'd255, 32'd0, 32'hFFFF_FFFF, 32'd0);
        send_command(mk_cmd(CMD_CENTER, 1'b0, 16'd0, 32'd0, 16'd1));
        send_command(mk_cmd(CMD_CENTER, 1'b0, 16'd0, 32'd0, 16'hFFFF));
        send_command(mk_cmd(CMD_CENTER, 1'b1, 16'd0, 32'd0, 16'd0));
        send_command(mk_cmd(CMD_SWEEP, 1'b1, 16'd0, 32'd0, 16'd0));
        wait_drained();

        // Random phases: sender idling at 36 %, then 66 %, then none.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            idle_pct = (ph < 2) ? 36 : (ph < 4) ? 66 : 0;
            load_config($urandom,
                        $urandom_range(0, 1) ? $urandom_range(0, 3100) : $urandom,
                        $urandom_range(0, 7) == 0 ? 32'd0 :
                            ($urandom_range(0, 1) ? $urandom_range(1, 5000) : $urandom),
                        $urandom_range(0, 9) == 0 ? 32'd0 : $urandom,
                        $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 300),
                        $urandom_range(0, 1) ? $urandom_range(0, 20000) : $urandom,
                        $urandom);
            if (ph == 3)
                write_reg(REG_NONE, $urandom);

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                r = $urandom_range(0, 99);
                c.cmd          = (r < 3) ? ($urandom_range(0, 1) ? CMD_SPARE_LO : CMD_SPARE_HI)
                                         : 3'($urandom_range(0, 5));
                c.dir_positive = 1'($urandom_range(0, 1));
                c.speed        = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 3100));
                r = $urandom_range(0, 19);
                c.pulse_count  = (r == 0) ? 32'd0 : (r < 10) ? $urandom_range(1, 100000) : $urandom;
                c.pixel_error  = $urandom_range(0, 1) ? 16'($urandom_range(0, 700) - 350)
                                                      : 16'($urandom);
                send_command(c);
                // now and then let the block run dry mid-phase
                if ($urandom_range(0, 39) == 0)
                    wait_drained();
            end
            wait_drained();
        end

        if (tracker.errors == 0 && tracker.owed_bytes.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
